@@ src/tne_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tne_pkg
// shared types, format codes and constant tables for the telemetry number
// exponent encoder
// ----------------------------------------------------------------------------
package tne_pkg;

    localparam int VALUE_W = 32;
    localparam int FMT_W   = 3;
    localparam int CODE_W  = 13;
    localparam int NUM_W   = 20;   // rounded dividend, below 2^20 where it is used
    localparam int RECIP_W = 20;
    localparam int QUOT_W  = 11;   // largest rounded quotient is 1024
    localparam int MANT_W  = 10;
    localparam int EXP_W   = 2;

    // format codes
    localparam logic [FMT_W-1:0] FMT_2DIG_P0 = 3'd0;
    localparam logic [FMT_W-1:0] FMT_2DIG_P1 = 3'd1;
    localparam logic [FMT_W-1:0] FMT_2DIG_P2 = 3'd2;
    localparam logic [FMT_W-1:0] FMT_3DIG_P1 = 3'd3;
    localparam logic [FMT_W-1:0] FMT_3DIG_P2 = 3'd4;

    // exponent codes
    localparam logic [EXP_W-1:0] EXP_0 = 2'd0;
    localparam logic [EXP_W-1:0] EXP_1 = 2'd1;
    localparam logic [EXP_W-1:0] EXP_2 = 2'd2;
    localparam logic [EXP_W-1:0] EXP_3 = 2'd3;

    // clamps and range limits
    localparam logic [VALUE_W-1:0] LIM_NEG_P0  = 32'd63;
    localparam logic [VALUE_W-1:0] LIM_POS_P0  = 32'd127;
    localparam logic [VALUE_W-1:0] LIM_100     = 32'd100;
    localparam logic [VALUE_W-1:0] LIM_1000    = 32'd1000;
    localparam logic [VALUE_W-1:0] LIM_10000   = 32'd10000;
    localparam logic [VALUE_W-1:0] LIM_100000  = 32'd100000;
    localparam logic [VALUE_W-1:0] LIM_1270    = 32'd1270;
    localparam logic [VALUE_W-1:0] LIM_127000  = 32'd127000;
    localparam logic [VALUE_W-1:0] LIM_10240   = 32'd10240;
    localparam logic [VALUE_W-1:0] LIM_1024000 = 32'd1024000;

    localparam logic [QUOT_W-1:0] TOP_2DIG = 11'd127;
    localparam logic [QUOT_W-1:0] TOP_3DIG = 11'd1023;

    localparam logic [7:0]  OVER_2DIG_P1 = 8'hFF;
    localparam logic [8:0]  OVER_2DIG_P2 = 9'h1FF;
    localparam logic [10:0] OVER_3DIG_P1 = 11'h7FF;
    localparam logic [11:0] OVER_3DIG_P2 = 12'hFFF;

    typedef enum logic [1:0] {
        KIND_DIRECT,
        KIND_DIV,
        KIND_OVER,
        KIND_ZERO
    } kind_t;

    typedef enum logic [1:0] {
        DIV_10,
        DIV_100,
        DIV_1000
    } div_sel_t;

    // reciprocal shifts: q = (n * recip) >> shift, exact for n < 2^20
    localparam int SHIFT_10   = 23;
    localparam int SHIFT_100  = 26;
    localparam int SHIFT_1000 = 29;

    typedef struct packed {
        logic               neg;
        logic [FMT_W-1:0]   fmt;
        kind_t              kind;
        div_sel_t           dsel;
        logic [EXP_W-1:0]   exp;
        logic [MANT_W-1:0]  direct;
        logic [NUM_W-1:0]   num;
    } mid_t;

    function automatic logic [RECIP_W-1:0] recip(input div_sel_t sel);
        logic [RECIP_W-1:0] r;
        unique case (sel)
            DIV_10:   r = 20'd838861;
            DIV_100:  r = 20'd671089;
            DIV_1000: r = 20'd536871;
            default:  r = 20'd838861;
        endcase
        return r;
    endfunction

    function automatic logic [NUM_W-1:0] half_div(input div_sel_t sel);
        logic [NUM_W-1:0] h;
        unique case (sel)
            DIV_10:   h = 20'd5;
            DIV_100:  h = 20'd50;
            DIV_1000: h = 20'd500;
            default:  h = 20'd5;
        endcase
        return h;
    endfunction

endpackage

@@ src/telemetry_number_exponent_encoder.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_number_exponent_encoder
// packs a signed 32-bit value into a sign / mantissa / power-of-ten exponent
// telemetry code in one of five formats
// ----------------------------------------------------------------------------
// usage:
//   s_value / s_format enter on a valid/ready channel; one transaction on the
//   input gives exactly one transaction on m_code, in order.
//   three register stages: input register, classify register (magnitude,
//   range class, rounded dividend), result register; an accepted input
//   passes through them in that order, and the result register drives m_code.
//   throughput is one transaction per cycle while m_ready stays high; the
//   only multiply is the reciprocal multiply for the divide by 10, 100 or
//   1000, which sits alone between the classify register and the result
//   register.
//   each stage loads when it is empty or the stage after it moves, so while
//   the receiver stalls with a result held on m_code, bubbles further up
//   still fill and s_ready stays high until all three stages are full.
//   aresetn (synchronous, active low) empties every stage; payload
//   registers are not cleared by it.
// ----------------------------------------------------------------------------
module telemetry_number_exponent_encoder
    import tne_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  logic [VALUE_W-1:0]  s_value,
    input  logic [FMT_W-1:0]    s_format,
    output logic                m_valid,
    input  logic                m_ready,
    output logic [CODE_W-1:0]   m_code
);

    // ------------------------------------------------------------------
    // stage registers
    // ------------------------------------------------------------------
    logic                in_valid_reg, in_valid_next;
    logic [VALUE_W-1:0]  in_value_reg, in_value_next;
    logic [FMT_W-1:0]    in_format_reg, in_format_next;
    logic                mid_valid_reg, mid_valid_next;
    mid_t                mid_reg, mid_next;
    logic                out_valid_reg, out_valid_next;
    logic [CODE_W-1:0]   out_code_reg, out_code_next;

    // stage advance enables, back to front
    logic out_load, mid_load, in_load;

    assign out_load = !out_valid_reg || m_ready;
    assign mid_load = !mid_valid_reg || out_load;
    assign in_load  = !in_valid_reg  || mid_load;

    assign s_ready = in_load;
    assign m_valid = out_valid_reg;
    assign m_code  = out_code_reg;

    // ------------------------------------------------------------------
    // classify: magnitude, range class, divisor and rounded dividend
    // ------------------------------------------------------------------
    logic               neg;
    logic [VALUE_W-1:0] mag;
    logic [VALUE_W-1:0] lim_p0;
    logic [VALUE_W-1:0] clamp_p0;

    always_comb begin
        neg      = in_value_reg[VALUE_W-1];
        // most negative input wraps to 2^31, which fits unsigned
        mag      = neg ? (~in_value_reg + 32'd1) : in_value_reg;
        lim_p0   = neg ? LIM_NEG_P0 : LIM_POS_P0;
        clamp_p0 = (mag > lim_p0) ? lim_p0 : mag;

        mid_next.neg    = neg;
        mid_next.fmt    = in_format_reg;
        mid_next.kind   = KIND_ZERO;
        mid_next.dsel   = DIV_10;
        mid_next.exp    = EXP_0;
        mid_next.direct = mag[MANT_W-1:0];

        case (in_format_reg)
            FMT_2DIG_P0: begin
                mid_next.kind   = KIND_DIRECT;
                mid_next.direct = clamp_p0[MANT_W-1:0];
            end
            FMT_2DIG_P1: begin
                if (mag < LIM_100) begin
                    mid_next.kind = KIND_DIRECT;
                end else if (mag < LIM_1270) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.exp  = EXP_1;
                end else begin
                    mid_next.kind = KIND_OVER;
                end
            end
            FMT_2DIG_P2: begin
                if (mag < LIM_100) begin
                    mid_next.kind = KIND_DIRECT;
                end else if (mag < LIM_1000) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.exp  = EXP_1;
                end else if (mag < LIM_10000) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.dsel = DIV_100;
                    mid_next.exp  = EXP_2;
                end else if (mag < LIM_127000) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.dsel = DIV_1000;
                    mid_next.exp  = EXP_3;
                end else begin
                    mid_next.kind = KIND_OVER;
                end
            end
            FMT_3DIG_P1: begin
                if (mag < LIM_1000) begin
                    mid_next.kind = KIND_DIRECT;
                end else if (mag < LIM_10240) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.exp  = EXP_1;
                end else begin
                    mid_next.kind = KIND_OVER;
                end
            end
            FMT_3DIG_P2: begin
                if (mag < LIM_1000) begin
                    mid_next.kind = KIND_DIRECT;
                end else if (mag < LIM_10000) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.exp  = EXP_1;
                end else if (mag < LIM_100000) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.dsel = DIV_100;
                    mid_next.exp  = EXP_2;
                end else if (mag < LIM_1024000) begin
                    mid_next.kind = KIND_DIV;
                    mid_next.dsel = DIV_1000;
                    mid_next.exp  = EXP_3;
                end else begin
                    mid_next.kind = KIND_OVER;
                end
            end
            default: begin
                mid_next.kind = KIND_ZERO;
            end
        endcase

        // round half up: add half the divisor; no carry out for the
        // divide ranges, all below 2^20 after the add
        mid_next.num = mag[NUM_W-1:0] + half_div(mid_next.dsel);
    end

    // ------------------------------------------------------------------
    // divide by reciprocal multiply, saturate, pack
    // ------------------------------------------------------------------
    logic [NUM_W+RECIP_W-1:0] prod;
    logic [QUOT_W-1:0]        quot;
    logic [QUOT_W-1:0]        top;
    logic [MANT_W-1:0]        quot_sat;
    logic [MANT_W-1:0]        mant;
    logic                     over;

    always_comb begin
        prod = mid_reg.num * recip(mid_reg.dsel);

        unique case (mid_reg.dsel)
            DIV_10:   quot = prod[SHIFT_10+QUOT_W-1:SHIFT_10];
            DIV_100:  quot = prod[SHIFT_100+QUOT_W-1:SHIFT_100];
            DIV_1000: quot = prod[SHIFT_1000+QUOT_W-1:SHIFT_1000];
            default:  quot = prod[SHIFT_10+QUOT_W-1:SHIFT_10];
        endcase

        // a quotient that rounds past the field saturates
        top      = ((mid_reg.fmt == FMT_2DIG_P1) || (mid_reg.fmt == FMT_2DIG_P2))
                   ? TOP_2DIG : TOP_3DIG;
        quot_sat = (quot > top) ? top[MANT_W-1:0] : quot[MANT_W-1:0];

        mant = (mid_reg.kind == KIND_DIV) ? quot_sat : mid_reg.direct;
        over = (mid_reg.kind == KIND_OVER);

        out_code_next = '0;
        if (mid_reg.kind != KIND_ZERO) begin
            case (mid_reg.fmt)
                FMT_2DIG_P0: begin
                    // negative clamp is 63, so for a negative value bit 6 is the sign alone
                    out_code_next = {6'd0, mant[6] | mid_reg.neg, mant[5:0]};
                end
                FMT_2DIG_P1: begin
                    out_code_next = {4'd0, mid_reg.neg,
                                     over ? OVER_2DIG_P1 : {mant[6:0], mid_reg.exp[0]}};
                end
                FMT_2DIG_P2: begin
                    out_code_next = {3'd0, mid_reg.neg,
                                     over ? OVER_2DIG_P2 : {mant[6:0], mid_reg.exp}};
                end
                FMT_3DIG_P1: begin
                    out_code_next = {1'b0, mid_reg.neg,
                                     over ? OVER_3DIG_P1 : {mant, mid_reg.exp[0]}};
                end
                FMT_3DIG_P2: begin
                    out_code_next = {mid_reg.neg,
                                     over ? OVER_3DIG_P2 : {mant, mid_reg.exp}};
                end
                default: begin
                    out_code_next = '0;
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // next-state of the stage registers
    // ------------------------------------------------------------------
    always_comb begin
        in_valid_next  = in_load  ? s_valid       : in_valid_reg;
        in_value_next  = in_load  ? s_value       : in_value_reg;
        in_format_next = in_load  ? s_format      : in_format_reg;
        mid_valid_next = mid_load ? in_valid_reg  : mid_valid_reg;
        out_valid_next = out_load ? mid_valid_reg : out_valid_reg;
    end

    // control state, reset clears
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            mid_valid_reg <= mid_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge aclk) begin
        in_value_reg  <= in_value_next;
        in_format_reg <= in_format_next;
        if (mid_load) begin
            mid_reg <= mid_next;
        end
        if (out_load) begin
            out_code_reg <= out_code_next;
        end
    end

endmodule

@@ tb/telemetry_number_exponent_encoder_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// telemetry_number_exponent_encoder_test
// checks the telemetry number encoder against an independent code predictor:
// a directed table of range edges, rounding and saturation points and
// unsupported formats, then random values drawn around every range class,
// with random idle cycles on the input and random stalls on the output
// ----------------------------------------------------------------------------
module telemetry_number_exponent_encoder_test;
    import tne_pkg::*;

    // formats the block does not support, they must give a zero code
    localparam logic [FMT_W-1:0] FMT_RSVD_5 = 3'd5;
    localparam logic [FMT_W-1:0] FMT_RSVD_6 = 3'd6;
    localparam logic [FMT_W-1:0] FMT_RSVD_7 = 3'd7;

    localparam int MAX_GAP      = 17;    // longest idle or stall per transaction
    localparam int HANG_LIMIT   = 1000;  // cycles with no transaction on either side
    localparam int DRAIN_CYCLES = 12;    // tail run once no codes are owed, to catch any extra result
    localparam int MAX_REPORTS  = 40;    // mismatch lines printed, all are counted
    localparam int NUM_BLOCKS   = 9;
    localparam int BLOCK_ITEMS  = 150;
    localparam int NUM_DIRECTED = 25;
    localparam int NUM_EDGES    = 17;

    // one directed row; when known is set the code is taken from the row
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [FMT_W-1:0]   fmt;
        logic               known;
        logic [CODE_W-1:0]  known_code;
    } vector_t;

    // one code owed by the block, kept with its input for the report line
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [FMT_W-1:0]   fmt;
        logic [CODE_W-1:0]  code;
    } owed_code_t;

    localparam logic [VALUE_W-1:0] INT_MIN = 32'h8000_0000;
    localparam logic [VALUE_W-1:0] INT_MAX = 32'h7FFF_FFFF;

    localparam vector_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        // plain 7-bit format: zero, clamp at 127 and at 63 with the sign bit
        '{32'd0,          FMT_2DIG_P0, 1'b1, 13'd0},
        '{32'd127,        FMT_2DIG_P0, 1'b1, 13'd127},
        '{-32'sd1,        FMT_2DIG_P0, 1'b1, 13'd65},
        '{INT_MIN,        FMT_2DIG_P0, 1'b1, 13'd127},
        '{INT_MAX,        FMT_2DIG_P0, 1'b1, 13'd127},
        // two digits, one exponent bit
        '{32'd99,         FMT_2DIG_P1, 1'b1, 13'd198},
        '{32'd1269,       FMT_2DIG_P1, 1'b0, 13'd0},
        '{32'd1270,       FMT_2DIG_P1, 1'b1, 13'h0FF},
        '{-32'sd1270,     FMT_2DIG_P1, 1'b1, 13'h1FF},
        // two digits, two exponent bits, each decade edge
        '{32'd995,        FMT_2DIG_P2, 1'b0, 13'd0},
        '{32'd9999,       FMT_2DIG_P2, 1'b0, 13'd0},
        '{-32'sd126999,   FMT_2DIG_P2, 1'b0, 13'd0},
        '{32'd127000,     FMT_2DIG_P2, 1'b1, 13'h1FF},
        '{INT_MAX,        FMT_2DIG_P2, 1'b1, 13'h1FF},
        // three digits, one exponent bit; 10235 rounds past the field
        '{32'd10235,      FMT_3DIG_P1, 1'b0, 13'd0},
        '{32'd10240,      FMT_3DIG_P1, 1'b1, 13'h7FF},
        '{-32'sd10239,    FMT_3DIG_P1, 1'b0, 13'd0},
        // three digits, two exponent bits; 1023999 rounds past the field
        '{32'd1023999,    FMT_3DIG_P2, 1'b0, 13'd0},
        '{32'd1024000,    FMT_3DIG_P2, 1'b1, 13'hFFF},
        '{INT_MIN,        FMT_3DIG_P2, 1'b1, 13'h1FFF},
        '{32'd999,        FMT_3DIG_P2, 1'b0, 13'd0},
        '{-32'sd99995,    FMT_3DIG_P2, 1'b0, 13'd0},
        // unsupported formats
        '{INT_MIN,        FMT_RSVD_5,  1'b1, 13'd0},
        '{INT_MAX,        FMT_RSVD_6,  1'b1, 13'd0},
        '{-32'sd1,        FMT_RSVD_7,  1'b1, 13'd0}
    };

    // magnitudes at class edges, clamp points and rounding points, random values land near them
    localparam logic [VALUE_W-1:0] RANGE_EDGES [NUM_EDGES] = '{
        32'd63, 32'd64, 32'd100, 32'd127, 32'd128, 32'd1000, 32'd1270, 32'd9995,
        32'd10000, 32'd10235, 32'd10240, 32'd99995, 32'd100000, 32'd126999,
        32'd127000, 32'd1023999, 32'd1024000
    };

    logic               aclk;
    logic               aresetn  = 1'b0;
    logic               s_valid  = 1'b0;
    logic               s_ready;
    logic [VALUE_W-1:0] s_value  = '0;
    logic [FMT_W-1:0]   s_format = '0;
    logic               m_valid;
    logic               m_ready  = 1'b0;
    logic [CODE_W-1:0]  m_code;

    owed_code_t owed_codes[$];   // codes accepted on the input, not yet seen on m_code
    owed_code_t oldest;
    int         mismatches  = 0;
    int         idle_cycles = 0;
    bit         sender_calm   = 1'b0;   // no idle cycles between input transactions
    bit         receiver_calm = 1'b0;   // m_ready held high

    telemetry_number_exponent_encoder dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_value  (s_value),
        .s_format (s_format),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_code   (m_code)
    );

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // code predictor
    // ------------------------------------------------------------------------

    // magnitude over div, rounded half up, held at top
    function automatic logic [31:0] rounded_mantissa(input logic [31:0] mag,
                                                     input logic [31:0] div,
                                                     input logic [31:0] top);
        logic [31:0] q;
        q = (mag + div / 32'd2) / div;
        return (q > top) ? top : q;
    endfunction

    function automatic logic [CODE_W-1:0] encode_telemetry(input logic [VALUE_W-1:0] value,
                                                           input logic [FMT_W-1:0]   fmt);
        logic        neg;
        logic [31:0] mag;
        logic [31:0] res;
        logic [31:0] top2;
        logic [31:0] top3;
        neg  = value[VALUE_W-1];
        // the most negative value wraps to 2^31, which is the magnitude wanted
        mag  = neg ? (32'd0 - value) : value;
        top2 = {21'd0, TOP_2DIG};
        top3 = {21'd0, TOP_3DIG};
        res  = '0;
        case (fmt)
            FMT_2DIG_P0: begin
                if (neg) begin
                    res    = (mag > LIM_NEG_P0) ? LIM_NEG_P0 : mag;
                    res[6] = 1'b1;
                end else begin
                    res = (mag > LIM_POS_P0) ? LIM_POS_P0 : mag;
                end
            end
            FMT_2DIG_P1: begin
                if (mag < LIM_100)
                    res = mag << 1;
                else if (mag < LIM_1270)
                    res = (rounded_mantissa(mag, 32'd10, top2) << 1) | {30'd0, EXP_1};
                else
                    res = {24'd0, OVER_2DIG_P1};
                res[8] = neg;
            end
            FMT_2DIG_P2: begin
                if (mag < LIM_100)
                    res = mag << 2;
                else if (mag < LIM_1000)
                    res = (rounded_mantissa(mag, 32'd10, top2) << 2) | {30'd0, EXP_1};
                else if (mag < LIM_10000)
                    res = (rounded_mantissa(mag, 32'd100, top2) << 2) | {30'd0, EXP_2};
                else if (mag < LIM_127000)
                    res = (rounded_mantissa(mag, 32'd1000, top2) << 2) | {30'd0, EXP_3};
                else
                    res = {23'd0, OVER_2DIG_P2};
                res[9] = neg;
            end
            FMT_3DIG_P1: begin
                if (mag < LIM_1000)
                    res = mag << 1;
                else if (mag < LIM_10240)
                    res = (rounded_mantissa(mag, 32'd10, top3) << 1) | {30'd0, EXP_1};
                else
                    res = {21'd0, OVER_3DIG_P1};
                res[11] = neg;
            end
            FMT_3DIG_P2: begin
                if (mag < LIM_1000)
                    res = mag << 2;
                else if (mag < LIM_10000)
                    res = (rounded_mantissa(mag, 32'd10, top3) << 2) | {30'd0, EXP_1};
                else if (mag < LIM_100000)
                    res = (rounded_mantissa(mag, 32'd100, top3) << 2) | {30'd0, EXP_2};
                else if (mag < LIM_1024000)
                    res = (rounded_mantissa(mag, 32'd1000, top3) << 2) | {30'd0, EXP_3};
                else
                    res = {20'd0, OVER_3DIG_P2};
                res[12] = neg;
            end
            default: res = '0;
        endcase
        return res[CODE_W-1:0];
    endfunction

    // ------------------------------------------------------------------------
    // random stimulus
    // ------------------------------------------------------------------------

    // values spread over every range class: small, near a class edge, on a
    // rounding half point, mid range, the two extremes, and anything at all
    function automatic logic [VALUE_W-1:0] draw_value();
        logic [31:0] mag;
        logic [31:0] div;
        case ($urandom_range(0, 9))
            0, 1: mag = $urandom_range(0, 150);
            2, 3: mag = RANGE_EDGES[$urandom_range(0, NUM_EDGES - 1)]
                        + $urandom_range(0, 6) - 32'd3;
            4, 5: begin
                case ($urandom_range(0, 2))
                    0:       div = 32'd10;
                    1:       div = 32'd100;
                    default: div = 32'd1000;
                endcase
                // just below or exactly on the half point between two mantissas
                mag = $urandom_range(0, 1100) * div + div / 32'd2 - $urandom_range(0, 1);
            end
            6:       mag = $urandom_range(0, 2000000);
            7:       return $urandom_range(0, 1) ? INT_MIN : INT_MAX;
            default: return $urandom;
        endcase
        return $urandom_range(0, 1) ? (32'd0 - mag) : mag;
    endfunction

    // mostly supported formats, about one in ten unsupported
    function automatic logic [FMT_W-1:0] draw_format();
        if ($urandom_range(0, 9) == 0)
            return FMT_W'($urandom_range(FMT_RSVD_5, FMT_RSVD_7));
        return FMT_W'($urandom_range(FMT_2DIG_P0, FMT_3DIG_P2));
    endfunction

    // ------------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------------

    // one input transaction: optional idle cycles, then valid held until accepted;
    // the owed code is queued at the accepting edge
    task automatic send_value(input logic [VALUE_W-1:0] value, input logic [FMT_W-1:0] fmt,
                              input logic known, input logic [CODE_W-1:0] known_code);
        int         gap;
        owed_code_t entry;
        gap = sender_calm ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid  <= 1'b1;
        s_value  <= value;
        s_format <= fmt;
        do @(posedge aclk); while (!s_ready);
        entry.value = value;
        entry.fmt   = fmt;
        entry.code  = known ? known_code : encode_telemetry(value, fmt);
        owed_codes.push_back(entry);
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // directed table, both sides idling at random
        for (int i = 0; i < NUM_DIRECTED; i++)
            send_value(DIRECTED_ROWS[i].value, DIRECTED_ROWS[i].fmt,
                       DIRECTED_ROWS[i].known, DIRECTED_ROWS[i].known_code);

        // random blocks cycle through idling on both sides, receiver only,
        // sender only and none, so back-to-back and stalled phases all occur
        for (int blk = 0; blk < NUM_BLOCKS; blk++) begin
            sender_calm   = (blk % 4 == 1) || (blk % 4 == 3);
            receiver_calm = (blk % 4 == 2) || (blk % 4 == 3);
            for (int i = 0; i < BLOCK_ITEMS; i++)
                send_value(draw_value(), draw_format(), 1'b0, '0);
        end
        sender_calm   = 1'b0;
        receiver_calm = 1'b0;
        s_valid <= 1'b0;

        // drain, then a short tail to catch any extra result
        while (owed_codes.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0)
            $display("** telemetry_number_exponent_encoder: PASSED **");
        else
            $display("** telemetry_number_exponent_encoder: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // output side
    // ------------------------------------------------------------------------

    // unless the receiver is calm, m_ready drops for a random number of cycles before every result
    initial begin
        int stall;
        while (!aresetn) @(posedge aclk);
        forever begin
            stall = receiver_calm ? 0 : $urandom_range(0, MAX_GAP);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
        end
    end

    task automatic report_mismatch(input string what, input owed_code_t want,
                                   input logic [CODE_W-1:0] got);
        if (mismatches < MAX_REPORTS)
            $display("[%0t] mismatch: %s value=%0d format=%0d code want=0x%h got=0x%h",
                     $realtime, what, $signed(want.value), want.fmt, want.code, got);
        mismatches++;
    endtask

    // every result transaction is matched against the oldest owed code
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (owed_codes.size() == 0) begin
                report_mismatch("result with nothing outstanding", '0, m_code);
            end else begin
                oldest = owed_codes.pop_front();
                if (m_code !== oldest.code)
                    report_mismatch("wrong code", oldest, m_code);
            end
        end
    end

    // hang detection: too long with no transaction on either channel
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= HANG_LIMIT) begin
            $display("[%0t] timeout, %0d codes outstanding", $realtime, owed_codes.size());
            $display("** telemetry_number_exponent_encoder: FAILED **");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

endmodule

@@ sim.f @@
src/tne_pkg.sv
src/telemetry_number_exponent_encoder.sv
tb/telemetry_number_exponent_encoder_test.sv
